// File: rtl/c3zpc_pkg.sv
package c3zpc_pkg;

  // pixel and coefficient widths
  localparam int PIX_W  = 8;
  localparam int KSIZE  = 3;
  localparam int COEF_W = 16;
  localparam int KROW_W = KSIZE * COEF_W;

  // geometry and counter widths
  localparam int FW_W   = 9;
  localparam int FH_W   = 16;
  localparam int TOT_W  = FW_W + FH_W;
  localparam int ROW_W  = 17;
  localparam int OCNT_W = 24;

  // datapath widths: unsigned pixel times signed coefficient, then sums
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int ACC_W  = RSUM_W + 2;

  // configuration port
  localparam int CFG_IDX_W = 3;

  localparam logic [FW_W-1:0]   FW_RESET   = 9'd220;
  localparam logic [FH_W-1:0]   FH_RESET   = 16'd220;
  localparam logic [KROW_W-1:0] KROW_RESET = 48'h01C7_01C7_01C7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MID    = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [KROW_W-1:0] krow_t;
  typedef krow_t [KSIZE-1:0] kernel_t;

  // one window handed from the line buffer front end to the multiply stages
  typedef struct packed {
    pix_t [KSIZE-1:0][KSIZE-1:0] taps;
    logic [KSIZE-1:0][KSIZE-1:0] tap_ok;
    logic                        last;
  } win_t;

endpackage

// File: rtl/c3zpc_ram.sv
module c3zpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/c3zpc_win.sv
module c3zpc_win
  import c3zpc_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pix_t             in_tdata,
  input  logic             in_tuser,
  input  logic [FW_W-1:0]  eff_width,
  input  logic [FH_W-1:0]  eff_height,
  input  logic [TOT_W-1:0] frame_total,
  output logic             win_valid,
  input  logic             win_ready,
  output win_t             win
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LS_W  = 2 * PIX_W;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  pix_t [KSIZE-1:0][KSIZE-1:0] pix_r, pix_nxt;
  logic [KSIZE-1:0][KSIZE-1:0] ok_r, ok_nxt;
  logic              last_r, last_nxt;
  logic              wv_r, wv_nxt;

  logic              accept;
  logic              due;
  pix_t              pix_in, up, lo;
  logic [LS_W-1:0]   ls_rd, ram_wdata, ram_rdata, byp_data_r;
  logic              byp_r;

  assign in_tready = !wv_r || win_ready;
  assign accept    = in_tvalid && in_tready;
  assign win_valid = wv_r;
  assign win.taps   = pix_r;
  assign win.tap_ok = ok_r;
  assign win.last   = last_r;

  // line store: upper row in the high byte, lower row in the low byte
  c3zpc_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (col_nxt),
    .rdata (ram_rdata)
  );

  // read data for the current column, with bypass when written and read at once
  assign ls_rd     = byp_r ? byp_data_r : ram_rdata;
  assign up        = ls_rd[LS_W-1:PIX_W];
  assign lo        = ls_rd[PIX_W-1:0];
  assign pix_in    = in_tuser ? '0 : in_tdata;
  assign ram_wdata = {lo, pix_in};

  // position tracking, window shift and padding masks
  always_comb begin
    logic [31:0] col32, ew32, eh32, row32, cbase, roff;
    logic [KSIZE-1:0] row_ok, col_ok;
    logic col0_case;
    logic last;

    col32 = 32'(col_r);
    ew32  = 32'(eff_width);
    eh32  = 32'(eff_height);
    row32 = 32'(row_r);

    due = (row32 >= 32'd2) || (row32 == 32'd1 && col32 != 32'd0) ||
          (row32 == 32'd0 && col32 >= ew32 + 32'd1);
    // first column of a row closes the last column of the row two above
    col0_case = due && (col32 == 32'd0);
    cbase     = col0_case ? ew32 : col32;
    roff      = col0_case ? 32'd3 : 32'd2;

    for (int k = 0; k < KSIZE; k++) begin
      row_ok[k] = (row32 + 32'(k) >= roff) && (row32 + 32'(k) - roff < eh32);
      col_ok[k] = (cbase + 32'(k) >= 32'd2) && (cbase + 32'(k) - 32'd2 < ew32);
    end

    last = (32'(ocnt_r) + 32'd1) >= 32'(frame_total);

    col_nxt  = col_r;
    row_nxt  = row_r;
    ocnt_nxt = ocnt_r;
    pix_nxt  = pix_r;
    ok_nxt   = ok_r;
    last_nxt = last_r;
    wv_nxt   = wv_r && !win_ready;

    if (accept) begin
      for (int i = 0; i < KSIZE; i++) begin
        pix_nxt[i][0] = pix_r[i][1];
        pix_nxt[i][1] = pix_r[i][2];
        for (int j = 0; j < KSIZE; j++) begin
          ok_nxt[i][j] = row_ok[i] && col_ok[j];
        end
      end
      pix_nxt[0][2] = up;
      pix_nxt[1][2] = lo;
      pix_nxt[2][2] = pix_in;
      last_nxt = last;
      wv_nxt   = due;

      if (col32 + 32'd1 >= ew32) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = COL_W'(col32 + 32'd1);
      end

      if (due) begin
        if (last) begin
          col_nxt  = '0;
          row_nxt  = '0;
          ocnt_nxt = '0;
        end else begin
          ocnt_nxt = ocnt_r + 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
      pix_r  <= '0;
      wv_r   <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocnt_r <= ocnt_nxt;
      pix_r  <= pix_nxt;
      wv_r   <= wv_nxt;
      byp_r  <= accept && (col_r == col_nxt);
    end
  end

  // window payload
  always_ff @(posedge clk) begin
    ok_r       <= ok_nxt;
    last_r     <= last_nxt;
    byp_data_r <= ram_wdata;
  end

endmodule

// File: rtl/c3zpc_mac.sv
module c3zpc_mac
  import c3zpc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    win_valid,
  output logic    win_ready,
  input  win_t    win,
  input  kernel_t kernel,
  output logic    out_tvalid,
  input  logic    out_tready,
  output pix_t    out_tdata,
  output logic    out_tlast
);

  logic signed [RSUM_W-1:0] rsum_r [KSIZE];
  logic signed [RSUM_W-1:0] rsum_nxt [KSIZE];
  logic                     s2_v_r, s2_last_r;
  logic                     out_v_r, out_last_r;
  pix_t                     out_pix_r, pix_res;
  logic                     out_ok, s2_ok;

  assign out_ok     = !out_v_r || out_tready;
  assign s2_ok      = !s2_v_r || out_ok;
  assign win_ready  = s2_ok;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // nine products, summed per kernel row
  always_comb begin
    logic signed [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod;
    pix_t                     pm;
    for (int i = 0; i < KSIZE; i++) begin
      rsum_nxt[i] = '0;
      for (int j = 0; j < KSIZE; j++) begin
        pm   = win.tap_ok[i][j] ? win.taps[i][j] : '0;
        coef = $signed(kernel[i][COEF_W*j +: COEF_W]);
        prod = $signed({1'b0, pm}) * coef;
        rsum_nxt[i] = rsum_nxt[i] + RSUM_W'(prod);
      end
    end
  end

  // final sum, truncate the fraction and clamp to 0..255
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < KSIZE; i++) begin
      acc = acc + ACC_W'(rsum_r[i]);
    end
    if (acc[ACC_W-1]) begin
      pix_res = '0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
      pix_res = '1;
    end else begin
      pix_res = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ok) begin
        s2_v_r <= win_valid;
      end
      if (out_ok) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s2_ok && win_valid) begin
      rsum_r    <= rsum_nxt;
      s2_last_r <= win.last;
    end
    if (out_ok && s2_v_r) begin
      out_pix_r  <= pix_res;
      out_last_r <= s2_last_r;
    end
  end

endmodule

// File: rtl/conv3x3_zero_pad_clamp.sv
// Streaming 3x3 convolution of one 8-bit image channel with one pixel of zero
// padding on each side, so the output frame matches the input frame in size.
// Pixels enter in raster order on in_tdata; in_tuser high marks a flush beat
// that acts as a zero pixel and pushes out the tail of the frame. The block
// takes one transfer per clock unless stalled: the line store is one dual-port
// RAM of MAX_WIDTH x 16 bits (one write and one registered read per clock,
// with a bypass for a same-address read) and the nine multiplies run in a
// pipeline. The result for pixel k is computed on the transfer that carries
// position k + width + 1 and passes the window, row-sum and output registers
// in turn on its way to out_tdata; an unaccepted transfer produces no
// result. Each result is the Q3.12 sum truncated toward zero and clamped to
// 0..255, and out_tlast marks the last pixel of the frame. The line store
// needs no clearing after reset, as padding masks every unwritten entry.
// Configuration is written through cfg_wen/cfg_idx/cfg_wdata while idle.
module conv3x3_zero_pad_clamp
  import c3zpc_pkg::*;
#(
  parameter int MAX_WIDTH      = 256,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,    // in_pixel
  input  logic                 in_tuser,    // func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,   // out_pixel
  output logic                 out_tlast,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [KROW_W-1:0]    cfg_wdata
);

  logic [FW_W-1:0]  ew_r, ew_nxt;
  logic [FH_W-1:0]  eh_r, eh_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  kernel_t          kernel_r, kernel_nxt;
  logic             win_valid, win_ready;
  win_t             win;

  // zero width or height counts as one; width is capped at the line store depth
  function automatic logic [FW_W-1:0] eff_w(input logic [FW_W-1:0] v);
    if (v == '0) begin
      return FW_W'(1);
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      return FW_W'(MAX_WIDTH);
    end
    return v;
  endfunction

  function automatic logic [FH_W-1:0] eff_h(input logic [FH_W-1:0] v);
    return (v == '0) ? FH_W'(1) : v;
  endfunction

  // register writes, frame size product kept alongside
  always_comb begin
    ew_nxt     = ew_r;
    eh_nxt     = eh_r;
    total_nxt  = total_r;
    kernel_nxt = kernel_r;
    if (cfg_wen) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH: begin
          ew_nxt    = eff_w(cfg_wdata[FW_W-1:0]);
          total_nxt = TOT_W'(eff_w(cfg_wdata[FW_W-1:0])) * TOT_W'(eh_r);
        end
        REG_FRAME_HEIGHT: begin
          eh_nxt    = eff_h(cfg_wdata[FH_W-1:0]);
          total_nxt = TOT_W'(ew_r) * TOT_W'(eff_h(cfg_wdata[FH_W-1:0]));
        end
        REG_KERNEL_TOP:    kernel_nxt[0] = cfg_wdata;
        REG_KERNEL_MID:    kernel_nxt[1] = cfg_wdata;
        REG_KERNEL_BOTTOM: kernel_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r     <= eff_w(FW_RESET);
      eh_r     <= FH_RESET;
      total_r  <= TOT_W'(eff_w(FW_RESET)) * TOT_W'(FH_RESET);
      kernel_r <= {KSIZE{KROW_RESET}};
    end else begin
      ew_r     <= ew_nxt;
      eh_r     <= eh_nxt;
      total_r  <= total_nxt;
      kernel_r <= kernel_nxt;
    end
  end

  // line buffer, window and position tracking
  c3zpc_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .eff_width   (ew_r),
    .eff_height  (eh_r),
    .frame_total (total_r),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .win         (win)
  );

  // multiply, sum, clamp and output register
  c3zpc_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .win        (win),
    .kernel     (kernel_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/c3zpc_chk.sv
module c3zpc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the output register empty the pipeline can always take a transfer
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a new result comes from an accepted input transfer, through the window, row-sum and output registers
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("result without matching input transfer");

endmodule

bind conv3x3_zero_pad_clamp c3zpc_chk u_chk (.*);

// File: tb/sv/conv3x3_zero_pad_clamp_test.sv
`timescale 1ns / 1ps

module conv3x3_zero_pad_clamp_test;
  import c3zpc_pkg::*;

  localparam int LINE_LEN      = 256;
  localparam int FRAC          = 12;
  localparam int SETTLE        = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_BEATS  = 850;
  localparam int SHOWN_ERRORS  = 10;
  localparam int WHOLE_FRAME   = 1 << 30;

  localparam logic [COEF_W-1:0] COEF_ONE  = 16'h1000;
  localparam logic [COEF_W-1:0] COEF_MAXP = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_MAXN = 16'h8000;

  // pixel choice per beat
  typedef enum int { PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_CORNERS } pix_mode_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] tap_grid_t;
  typedef struct packed {
    pix_t pixel;
    logic last;
  } out_px_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata;    // in_pixel
  logic                 in_tuser;    // func
  logic                 out_tvalid;
  logic                 out_tready;
  logic [PIX_W-1:0]     out_tdata;   // out_pixel
  logic                 out_tlast;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [KROW_W-1:0]    cfg_wdata;

  conv3x3_zero_pad_clamp uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor copy of configuration and filter state
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  krow_t           kernel_reg [KSIZE];
  pix_t            upper_row [LINE_LEN];
  pix_t            lower_row [LINE_LEN];
  tap_grid_t       win;
  int unsigned     col_pos;
  int unsigned     row_pos;
  int unsigned     done_count;
  bit              frame_ended;
  out_px_t         filtered_q [$];

  int in_gap_max;
  int out_gap_max;
  bit hold_req;
  int beats_sent;
  int flush_sent;
  int results_seen;
  int frames_seen;
  int writes_done;
  int holds_done;
  int errors;
  out_px_t want_px;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("conv3x3_zero_pad_clamp_test: done, errors");
    $finish;
  end

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_LEN) return LINE_LEN;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // nine taps times signed Q3.12 coefficients, taps outside the frame masked
  function automatic pix_t filter_taps(tap_grid_t taps, longint trow, longint tcol);
    longint acc;
    longint r;
    longint c;
    logic signed [COEF_W-1:0] k;
    acc = 0;
    for (int i = 0; i < KSIZE; i++) begin
      r = trow - 1 + i;
      if (r >= 0 && r < eff_h()) begin
        for (int j = 0; j < KSIZE; j++) begin
          c = tcol - 1 + j;
          if (c >= 0 && c < eff_w()) begin
            k = kernel_reg[i][COEF_W*j +: COEF_W];
            acc += longint'(taps[i][j]) * longint'(k);
          end
        end
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> FRAC;
    return (acc > 255) ? 8'hFF : pix_t'(acc);
  endfunction

  // advance the filter by one accepted beat, queue the pixel it releases
  task automatic filter_beat(input logic fl, input pix_t px);
    int w;
    int idx;
    longint pos;
    longint total;
    bit due;
    pix_t v;
    pix_t up;
    pix_t lo;
    pix_t res;
    tap_grid_t side_taps;
    w = eff_w();
    v = fl ? '0 : px;
    pos = longint'(row_pos) * w + col_pos;
    due = pos >= w + 1;
    res = '0;
    // column 0 releases the last pixel of an earlier row, right side padded
    if (due && col_pos == 0) begin
      for (int i = 0; i < KSIZE; i++) begin
        side_taps[i][0] = win[i][1];
        side_taps[i][1] = win[i][2];
        side_taps[i][2] = '0;
      end
      res = filter_taps(side_taps, longint'(row_pos) - 2, w - 1);
    end
    // line stores and window shift
    idx = col_pos % LINE_LEN;
    up = upper_row[idx];
    lo = lower_row[idx];
    upper_row[idx] = lo;
    lower_row[idx] = v;
    for (int i = 0; i < KSIZE; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = v;
    if (due && col_pos != 0)
      res = filter_taps(win, longint'(row_pos) - 1, longint'(col_pos) - 1);
    // position counters
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'h1FFFF;
    end
    frame_ended = 1'b0;
    if (due) begin
      total = longint'(w) * eff_h();
      want_px.pixel = res;
      want_px.last  = (longint'(done_count) + 1 >= total);
      filtered_q.push_back(want_px);
      if (want_px.last) begin
        col_pos = 0;
        row_pos = 0;
        done_count = 0;
        frame_ended = 1'b1;
        frames_seen++;
      end else begin
        done_count = (done_count + 1) & 32'hFFFFFF;
      end
    end
  endtask

  task automatic reset_predictor();
    width_reg = FW_RESET;
    height_reg = FH_RESET;
    for (int i = 0; i < KSIZE; i++) kernel_reg[i] = KROW_RESET;
    for (int i = 0; i < LINE_LEN; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    win = '0;
    col_pos = 0;
    row_pos = 0;
    done_count = 0;
    frame_ended = 1'b0;
  endtask

  // one input transfer, after a random gap
  task automatic send_beat(input logic fl, input pix_t px);
    int gap;
    bit ok;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= fl;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    filter_beat(fl, px);
    beats_sent++;
    if (fl) flush_sent++;
  endtask

  function automatic pix_t pick_pixel(pix_mode_t mode);
    case (mode)
      PIX_WHITE: return 8'hFF;
      PIX_BLACK: return 8'h00;
      PIX_CORNERS: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'hAA;
          default: return 8'h55;
        endcase
      end
      default: return pix_t'($urandom);
    endcase
  endfunction

  // beats until the frame closes or the limit is hit; tail positions are flushes
  task automatic send_beats(input int limit, input int flush_pct, input pix_mode_t mode);
    int n;
    longint pos;
    logic fl;
    n = 0;
    do begin
      pos = longint'(row_pos) * eff_w() + col_pos;
      if (pos >= longint'(eff_w()) * eff_h()) fl = 1'b1;
      else fl = ($urandom_range(0, 99) < flush_pct);
      send_beat(fl, pick_pixel(mode));
      n++;
    end while (!frame_ended && n < limit);
  endtask

  // sender pause until every expected pixel is back and the pipe is quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input krow_t v);
    cfg_wen <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (r)
      REG_FRAME_WIDTH:   width_reg = v[FW_W-1:0];
      REG_FRAME_HEIGHT:  height_reg = v[FH_W-1:0];
      REG_KERNEL_TOP:    kernel_reg[0] = v;
      REG_KERNEL_MID:    kernel_reg[1] = v;
      REG_KERNEL_BOTTOM: kernel_reg[2] = v;
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(REG_FRAME_WIDTH, krow_t'(w));
    write_reg(REG_FRAME_HEIGHT, krow_t'(h));
  endtask

  task automatic set_kernel(input krow_t top, input krow_t mid, input krow_t bottom);
    write_reg(REG_KERNEL_TOP, top);
    write_reg(REG_KERNEL_MID, mid);
    write_reg(REG_KERNEL_BOTTOM, bottom);
  endtask

  function automatic krow_t coef_row(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                     logic [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  // coefficients about -0.25..0.5, so sums spread over the pixel range
  function automatic krow_t mild_row();
    krow_t r;
    for (int j = 0; j < KSIZE; j++)
      r[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 3072) - 1024);
    return r;
  endfunction

  function automatic krow_t extreme_row();
    krow_t r;
    for (int j = 0; j < KSIZE; j++) begin
      case ($urandom_range(0, 3))
        0: r[COEF_W*j +: COEF_W] = COEF_MAXP;
        1: r[COEF_W*j +: COEF_W] = COEF_MAXN;
        2: r[COEF_W*j +: COEF_W] = '0;
        default: r[COEF_W*j +: COEF_W] = '1;
      endcase
    end
    return r;
  endfunction

  function automatic krow_t any_row();
    case ($urandom_range(0, 7))
      6: return krow_t'({$urandom, $urandom});
      7: return extreme_row();
      default: return mild_row();
    endcase
  endfunction

  // two full rows at the widest setting: every line store entry gets written
  task automatic test_full_width_frame();
    in_gap_max = 0;
    out_gap_max = 19;
    set_geometry(511, 2);
    send_beats(WHOLE_FRAME, 0, PIX_RANDOM);
  endtask

  // zero geometry acts as one, single column frames
  task automatic test_zero_geometry();
    drain_results();
    in_gap_max = 19;
    set_geometry(0, 0);
    send_beats(WHOLE_FRAME, 0, PIX_CORNERS);
    drain_results();
    set_geometry(1, 3);
    send_beats(WHOLE_FRAME, 0, PIX_CORNERS);
  endtask

  // saturation both ways, identity and a single corner tap
  task automatic test_kernel_extremes();
    drain_results();
    set_geometry(2, 2);
    set_kernel(coef_row(COEF_MAXP, COEF_MAXP, COEF_MAXP),
               coef_row(COEF_MAXP, COEF_MAXP, COEF_MAXP),
               coef_row(COEF_MAXP, COEF_MAXP, COEF_MAXP));
    send_beats(WHOLE_FRAME, 0, PIX_WHITE);
    drain_results();
    set_kernel(coef_row(COEF_MAXN, COEF_MAXN, COEF_MAXN),
               coef_row(COEF_MAXN, COEF_MAXN, COEF_MAXN),
               coef_row(COEF_MAXN, COEF_MAXN, COEF_MAXN));
    send_beats(WHOLE_FRAME, 0, PIX_WHITE);
    drain_results();
    set_kernel('0, coef_row('0, COEF_ONE, '0), '0);
    send_beats(WHOLE_FRAME, 0, PIX_CORNERS);
    drain_results();
    set_geometry(3, 2);
    set_kernel(coef_row(COEF_ONE, '0, '0), '0, '0);
    send_beats(WHOLE_FRAME, 0, PIX_RANDOM);
    drain_results();
    set_kernel(KROW_RESET, KROW_RESET, KROW_RESET);
  endtask

  // flush beats inside the frame count as black pixels
  task automatic test_flush_in_frame();
    drain_results();
    set_geometry(3, 3);
    send_beats(WHOLE_FRAME, 50, PIX_WHITE);
  endtask

  // geometry rewritten part way through a frame, grown and then shrunk
  task automatic test_mid_frame_reshape();
    drain_results();
    set_kernel(mild_row(), mild_row(), mild_row());
    set_geometry(4, 3);
    send_beats(7, 0, PIX_RANDOM);
    drain_results();
    set_geometry(6, 2);
    send_beats(WHOLE_FRAME, 0, PIX_RANDOM);
    drain_results();
    set_geometry(5, 4);
    send_beats(12, 0, PIX_RANDOM);
    drain_results();
    set_geometry(5, 1);
    send_beats(WHOLE_FRAME, 0, PIX_RANDOM);
  endtask

  // long receiver hold fills the pipe, then a sender pause mid frame
  task automatic test_receiver_hold();
    drain_results();
    set_geometry(8, 6);
    in_gap_max = 0;
    hold_req = 1'b1;
    send_beats(30, 0, PIX_RANDOM);
    drain_results();
    in_gap_max = 19;
    send_beats(WHOLE_FRAME, 0, PIX_RANDOM);
  endtask

  // mostly complete frames of random shape and kernel, some cut short
  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int pick;
    int flush_pct;
    pix_mode_t mode;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      drain_results();
      pick = $urandom_range(0, 24);
      if (pick == 0) begin
        w = $urandom_range(65, 300);
        h = 1;
      end else if (pick < 3) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      set_geometry(w, h);
      if ($urandom_range(0, 3) != 0) set_kernel(any_row(), any_row(), any_row());
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      flush_pct = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 5);
      mode = ($urandom_range(0, 5) == 0) ? PIX_CORNERS : PIX_RANDOM;
      // broken frame: stop part way and reshape before finishing it
      if ($urandom_range(0, 7) == 0) begin
        send_beats($urandom_range(1, 20), flush_pct, mode);
        if (!frame_ended) begin
          drain_results();
          set_geometry($urandom_range(1, 12), $urandom_range(1, 6));
        end
      end
      send_beats(WHOLE_FRAME, flush_pct, mode);
    end
  endtask

  // receiver: random stall before each transfer, long hold on request
  initial begin
    int n;
    bit fire;
    bit holding;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      holding = hold_req;
      hold_req = 1'b0;
      n = holding ? HOLD_CYCLES : $urandom_range(0, out_gap_max);
      if (holding) holds_done++;
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        fire = out_tvalid;
        @(posedge clk);
      end while (!fire);
    end
  end

  // compare each result transfer with the oldest expected pixel
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected result %0d: pixel %0d last %0b",
                   results_seen, out_tdata, out_tlast);
      end else begin
        want_px = filtered_q.pop_front();
        if (out_tdata !== want_px.pixel || out_tlast !== want_px.last) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("mismatch at result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                     results_seen, want_px.pixel, want_px.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_wen <= 1'b0;
    cfg_idx <= REG_FRAME_WIDTH;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    in_gap_max = 19;
    out_gap_max = 19;
    hold_req = 1'b0;
    beats_sent = 0;
    flush_sent = 0;
    results_seen = 0;
    frames_seen = 0;
    writes_done = 0;
    holds_done = 0;
    errors = 0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_width_frame();
    test_zero_geometry();
    test_kernel_extremes();
    test_flush_in_frame();
    test_mid_frame_reshape();
    test_receiver_hold();
    test_random_frames();

    drain_results();
    if (filtered_q.size() != 0) errors += filtered_q.size();
    $display("covered %0d input transfers (%0d flush) and %0d filtered pixels in %0d frames",
             beats_sent, flush_sent, results_seen, frames_seen);
    $display("with %0d register writes, %0d long output holds, %0d mismatches",
             writes_done, holds_done, errors);
    if (errors == 0) begin
      $display("conv3x3_zero_pad_clamp_test: done, clean");
    end else begin
      $display("conv3x3_zero_pad_clamp_test: done, errors");
    end
    $finish;
  end

endmodule
